// File: rtl/fitu_pkg.sv
// fitu_pkg: shared types, opcodes and fixed-point constants for the inverse trig unit.
// Used by every module of the unit and by its checker; no dependencies.
package fitu_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS   = 16;               // operand/result fraction bits
   localparam int WF          = 30;               // internal angle fraction bits
   localparam int VW          = WF + 1;           // width of Q30 values up to 1.0
   localparam int ROUND_SHIFT = WF - FRAC_BITS;
   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam logic [VW-1:0] ONE_W = VW'(1) << WF;

   // Angle constants in Q30
   localparam logic [31:0] PI_W   = 32'd3373259426;
   localparam logic [31:0] PI2_W  = PI_W >> 1;
   localparam logic [31:0] PI4_W  = PI_W >> 2;
   localparam logic [28:0] K309_W = 29'd331786224;

   // Chain lengths and total latency from request to result
   localparam int SQ_STEPS   = 32;
   localparam int DIV_STEPS  = WF + 1;
   localparam int PIPE_DEPTH = SQ_STEPS + DIV_STEPS + 7;

   // Reset values of the control registers
   localparam logic [16:0] EPS_RESET     = 17'd66;
   localparam logic [18:0] ACOS_M1_RESET = 19'd205887;

   typedef enum logic [2:0] {
      OP_ATAN2  = 3'd0,
      OP_ASIN   = 3'd1,
      OP_ACOS   = 3'd2,
      OP_SQRT   = 3'd3,
      OP_LEN2D  = 3'd4,
      OP_LEN3D  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ACOS_CALC,
      ACOS_AT_M1,
      ACOS_ZERO
   } acos_type;

   typedef enum logic [0:0] {
      CSR_EPSILON = 1'b0,
      CSR_ACOS_M1 = 1'b1
   } csr_type;

   // Per-request context that travels down the chains
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        a_neg;
      logic        b_neg;
      logic        neg;
      logic        xneg;
      logic        zero;
      logic        swapped;
      acos_type    acos;
      logic [31:0] amag;
      logic [31:0] bmag;
      logic [31:0] rootv;
   } ctx_type;

   // One square-root lane: radicand still to consume, partial remainder and root
   typedef struct packed {
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sq_lane_type;

   // One divider lane: partial remainder, divisor and quotient so far
   typedef struct packed {
      logic [32:0]   rem;
      logic [31:0]   hi;
      logic [VW-1:0] q;
   } div_lane_type;

endpackage

// File: rtl/fitu_sqrt_cell.sv
// fitu_sqrt_cell: one digit step of two floor square roots, plus the request context.
// Depends on fitu_pkg.
module fitu_sqrt_cell
   import fitu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctx_type               up_ctx,
   input  sq_lane_type [1:0]     up_lane,
   output ctx_type               dn_ctx,
   output sq_lane_type [1:0]     dn_lane
);

   ctx_type           ctx_ff;
   sq_lane_type [1:0] lane_ff, lane_in;
   logic [35:0]       cur  [2];
   logic [35:0]       trial[2];

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         cur[k]   = {up_lane[k].rem, up_lane[k].rad[63:62]};
         trial[k] = {2'b00, up_lane[k].root, 2'b01};
         lane_in[k].rad = {up_lane[k].rad[61:0], 2'b00};
         if (cur[k] >= trial[k]) begin
            lane_in[k].rem  = 34'(cur[k] - trial[k]);
            lane_in[k].root = {up_lane[k].root[30:0], 1'b1};
         end else begin
            lane_in[k].rem  = cur[k][33:0];
            lane_in[k].root = {up_lane[k].root[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.valid <= 1'b0;
      end else begin
         ctx_ff.valid <= up_ctx.valid;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[$bits(ctx_type)-2:0] <= up_ctx[$bits(ctx_type)-2:0];
      lane_ff                     <= lane_in;
   end

   assign dn_ctx  = ctx_ff;
   assign dn_lane = lane_ff;

endmodule

// File: rtl/fitu_div_cell.sv
// fitu_div_cell: one restoring step of the octant ratio division, plus the request context.
// Depends on fitu_pkg.
module fitu_div_cell
   import fitu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctx_type       up_ctx,
   input  div_lane_type  up_lane,
   output ctx_type       dn_ctx,
   output div_lane_type  dn_lane
);

   ctx_type      ctx_ff;
   div_lane_type lane_ff, lane_in;
   logic [32:0]  diff;
   logic         take;

   // Compare against the divisor, subtract on success, shift for the next bit
   always_comb begin
      take         = up_lane.rem >= {1'b0, up_lane.hi};
      diff         = take ? (up_lane.rem - {1'b0, up_lane.hi}) : up_lane.rem;
      lane_in.rem  = {diff[31:0], 1'b0};
      lane_in.hi   = up_lane.hi;
      lane_in.q    = {up_lane.q[VW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.valid <= 1'b0;
      end else begin
         ctx_ff.valid <= up_ctx.valid;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff[$bits(ctx_type)-2:0] <= up_ctx[$bits(ctx_type)-2:0];
      lane_ff                     <= lane_in;
   end

   assign dn_ctx  = ctx_ff;
   assign dn_lane = lane_ff;

endmodule

// File: rtl/fast_inverse_trig_unit_top.sv
// fast_inverse_trig_unit_top: Q16.16 atan2/asin/acos/sqrt/length unit, fully pipelined.
// Depends on fitu_pkg, fitu_sqrt_cell and fitu_div_cell.

// The unit takes one request every clock cycle (busy stays low) and returns each result
// in request order, as a one-cycle rsp_valid strobe; the receiver cannot stall it, so
// the result must be captured on that cycle. The pipeline is made of two operand stages,
// a row of 32 square-root cells (one root bit per cell, two lanes), a select stage, a row
// of 31 divider cells (one quotient bit per cell), three polynomial multiply stages and an
// output stage. Control registers are written through the csr_ port, which is always
// ready, and should only be written while no request is in flight.
module fast_inverse_trig_unit_top
   import fitu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [31:0] req_operand_c,
   // result channel
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_saturated,
   // control register port
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // ---------------------------------------------------------------- control registers
   logic [16:0] eps_ff;
   logic [18:0] acos_m1_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff     <= EPS_RESET;
         acos_m1_ff <= ACOS_M1_RESET;
      end else if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_EPSILON: eps_ff     <= csr_data[16:0];
            CSR_ACOS_M1: acos_m1_ff <= csr_data[18:0];
            default:     ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1: magnitudes, squares
   ctx_type            s1_ctx_ff, s1_ctx_in;
   logic [63:0]        s1_m0_ff, s1_m1_ff, s1_m2_ff, s1_m0_in, s1_m1_in, s1_m2_in;
   logic [VW-1:0]      s1_t_ff, s1_t_in;
   logic               s1_small_ff, s1_small_in;
   logic signed [31:0] s1_a_ff;
   logic [31:0]        a_mag, b_mag, c_mag, a_clamp, x0;
   logic [VW-1:0]      v;

   always_comb begin
      a_mag   = req_operand_a[31] ? (~req_operand_a + 32'd1) : req_operand_a;
      b_mag   = req_operand_b[31] ? (~req_operand_b + 32'd1) : req_operand_b;
      c_mag   = req_operand_c[31] ? (~req_operand_c + 32'd1) : req_operand_c;
      // asin argument clamped to one, then widened to Q30
      a_clamp = (a_mag > 32'(ONE_Q)) ? 32'(ONE_Q) : a_mag;
      v       = VW'(a_clamp) << ROUND_SHIFT;
      s1_t_in = ONE_W - v;
      s1_small_in = v < (ONE_W >> 1);
      x0      = (op_type'(req_operation) == OP_ASIN) ?
                32'(s1_small_in ? v : s1_t_in) : a_mag;
      s1_m0_in = 64'(x0) * 64'(x0);
      s1_m1_in = 64'(b_mag) * 64'(b_mag);
      s1_m2_in = 64'(c_mag) * 64'(c_mag);

      s1_ctx_in         = '0;
      s1_ctx_in.valid   = start & ~busy;
      s1_ctx_in.op      = op_type'(req_operation);
      s1_ctx_in.a_neg   = req_operand_a[31];
      s1_ctx_in.b_neg   = req_operand_b[31];
      s1_ctx_in.amag    = (op_type'(req_operation) == OP_ASIN) ? 32'(v) : a_mag;
      s1_ctx_in.bmag    = b_mag;
      s1_ctx_in.acos    = ACOS_CALC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctx_ff.valid <= 1'b0;
      end else begin
         s1_ctx_ff.valid <= s1_ctx_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctx_ff[$bits(ctx_type)-2:0] <= s1_ctx_in[$bits(ctx_type)-2:0];
      s1_m0_ff    <= s1_m0_in;
      s1_m1_ff    <= s1_m1_in;
      s1_m2_ff    <= s1_m2_in;
      s1_t_ff     <= s1_t_in;
      s1_small_ff <= s1_small_in;
      s1_a_ff     <= req_operand_a;
   end

   // ---------------------------------------------------------------- stage 2: radicands, acos bands
   ctx_type           s2_ctx_ff, s2_ctx_in;
   sq_lane_type [1:0] s2_lane_ff, s2_lane_in;
   logic signed [33:0] tq, nq, dq;
   logic [33:0]       t_abs, d_abs;

   always_comb begin
      tq    = 34'(s1_a_ff) + 34'(ONE_Q);
      nq    = 34'(ONE_Q) - 34'(s1_a_ff);
      dq    = 34'(s1_a_ff) - 34'(ONE_Q);
      t_abs = tq[33] ? 34'(-tq) : 34'(tq);
      d_abs = dq[33] ? 34'(-dq) : 34'(dq);

      s2_ctx_in = s1_ctx_ff;
      // acos near minus one, near plus one and beyond the domain
      if ((t_abs < 34'(eps_ff)) || (tq == 34'sd0)) begin
         s2_ctx_in.acos = ACOS_AT_M1;
      end else if (d_abs < 34'(eps_ff)) begin
         s2_ctx_in.acos = ACOS_ZERO;
      end else if (tq[33] || (nq <= 34'sd0)) begin
         s2_ctx_in.acos = ACOS_ZERO;
      end else begin
         s2_ctx_in.acos = ACOS_CALC;
      end

      s2_lane_in = '0;
      unique case (s1_ctx_ff.op)
         OP_ASIN: begin
            s2_lane_in[0].rad = s1_small_ff ? ((64'(ONE_W) << WF) - s1_m0_ff) :
                                              ((64'(s1_t_ff) << (WF + 1)) - s1_m0_ff);
         end
         OP_ACOS:  s2_lane_in[0].rad = 64'(tq[31:0]) << 32;
         OP_SQRT:  s2_lane_in[0].rad = s1_a_ff[31] ? 64'd0 :
                                       (64'(unsigned'(s1_a_ff)) << FRAC_BITS);
         OP_LEN2D: s2_lane_in[0].rad = s1_m0_ff + s1_m1_ff;
         OP_LEN3D: s2_lane_in[0].rad = s1_m0_ff + s1_m1_ff + s1_m2_ff;
         default:  s2_lane_in[0].rad = 64'd0;
      endcase
      s2_lane_in[1].rad = 64'(nq[31:0]) << 32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctx_ff.valid <= 1'b0;
      end else begin
         s2_ctx_ff.valid <= s2_ctx_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctx_ff[$bits(ctx_type)-2:0] <= s2_ctx_in[$bits(ctx_type)-2:0];
      s2_lane_ff                     <= s2_lane_in;
   end

   // ---------------------------------------------------------------- square-root cell row
   ctx_type           sq_ctx  [SQ_STEPS+1];
   sq_lane_type [1:0] sq_lane [SQ_STEPS+1];

   assign sq_ctx[0]  = s2_ctx_ff;
   assign sq_lane[0] = s2_lane_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      fitu_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_ctx  (sq_ctx[k]),
         .up_lane (sq_lane[k]),
         .dn_ctx  (sq_ctx[k+1]),
         .dn_lane (sq_lane[k+1])
      );
   end

   // ---------------------------------------------------------------- select: octant fold
   ctx_type      sel_ctx_ff, sel_ctx_in;
   div_lane_type sel_lane_ff, sel_lane_in;
   logic [31:0]  ay, ax, root0, root1;
   ctx_type      sq_out;

   always_comb begin
      sq_out = sq_ctx[SQ_STEPS];
      root0  = sq_lane[SQ_STEPS][0].root;
      root1  = sq_lane[SQ_STEPS][1].root;
      unique case (sq_out.op)
         OP_ATAN2: begin ay = sq_out.amag; ax = sq_out.bmag; end
         OP_ASIN:  begin ay = sq_out.amag; ax = root0;       end
         OP_ACOS:  begin ay = root1;       ax = root0;       end
         default:  begin ay = sq_out.amag; ax = sq_out.bmag; end
      endcase

      sel_ctx_in         = sq_out;
      sel_ctx_in.rootv   = root0;
      sel_ctx_in.zero    = (ay == 32'd0) && (ax == 32'd0);
      sel_ctx_in.swapped = ax < ay;
      sel_ctx_in.xneg    = (sq_out.op == OP_ATAN2) & sq_out.b_neg;
      sel_ctx_in.neg     = ((sq_out.op == OP_ATAN2) || (sq_out.op == OP_ASIN)) &
                           sq_out.a_neg;

      sel_lane_in.hi  = sel_ctx_in.swapped ? ay : ax;
      sel_lane_in.rem = {1'b0, (sel_ctx_in.swapped ? ax : ay)};
      sel_lane_in.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ctx_ff.valid <= 1'b0;
      end else begin
         sel_ctx_ff.valid <= sel_ctx_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      sel_ctx_ff[$bits(ctx_type)-2:0] <= sel_ctx_in[$bits(ctx_type)-2:0];
      sel_lane_ff                     <= sel_lane_in;
   end

   // ---------------------------------------------------------------- divider cell row
   ctx_type      dv_ctx  [DIV_STEPS+1];
   div_lane_type dv_lane [DIV_STEPS+1];

   assign dv_ctx[0]  = sel_ctx_ff;
   assign dv_lane[0] = sel_lane_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      fitu_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_ctx  (dv_ctx[k]),
         .up_lane (dv_lane[k]),
         .dn_ctx  (dv_ctx[k+1]),
         .dn_lane (dv_lane[k+1])
      );
   end

   // ---------------------------------------------------------------- polynomial, three stages
   ctx_type       m1_ctx_ff, m2_ctx_ff, m3_ctx_ff;
   logic [60:0]   m1_p1_ff;
   logic [61:0]   m1_p2_ff;
   logic [30:0]   m2_term_ff;
   logic [63:0]   m2_p3_ff;
   logic [31:0]   m3_mag_ff, m3_mag_in, ret;
   logic [VW-1:0] ratio;

   assign ratio = dv_lane[DIV_STEPS].q;

   // quadrant correction of pi/4*r + 0.309*r*(1-r)
   always_comb begin
      ret = 32'(m2_term_ff) + 32'(m2_p3_ff >> WF);
      if (m2_ctx_ff.zero) begin
         m3_mag_in = 32'd0;
      end else if (!m2_ctx_ff.xneg) begin
         m3_mag_in = m2_ctx_ff.swapped ? (PI2_W - ret) : ret;
      end else if (m2_ctx_ff.swapped) begin
         m3_mag_in = PI2_W + ret;
      end else begin
         m3_mag_in = PI_W - ret;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctx_ff.valid <= 1'b0;
         m2_ctx_ff.valid <= 1'b0;
         m3_ctx_ff.valid <= 1'b0;
      end else begin
         m1_ctx_ff.valid <= dv_ctx[DIV_STEPS].valid;
         m2_ctx_ff.valid <= m1_ctx_ff.valid;
         m3_ctx_ff.valid <= m2_ctx_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      m1_ctx_ff[$bits(ctx_type)-2:0] <= dv_ctx[DIV_STEPS][$bits(ctx_type)-2:0];
      m1_p1_ff   <= 61'(PI4_W[29:0]) * 61'(ratio);
      m1_p2_ff   <= 62'(ratio) * 62'(ONE_W - ratio);
      m2_ctx_ff[$bits(ctx_type)-2:0] <= m1_ctx_ff[$bits(ctx_type)-2:0];
      m2_term_ff <= 31'(m1_p1_ff >> WF);
      m2_p3_ff   <= 64'(K309_W) * 64'(m1_p2_ff >> WF);
      m3_ctx_ff[$bits(ctx_type)-2:0] <= m2_ctx_ff[$bits(ctx_type)-2:0];
      m3_mag_ff  <= m3_mag_in;
   end

   // ---------------------------------------------------------------- output stage
   logic        out_valid_ff;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_sat_ff, out_sat_in;
   logic [32:0] mag2;
   logic [33:0] rounded;
   logic [31:0] angle;

   always_comb begin
      mag2    = (m3_ctx_ff.op == OP_ACOS) ? {m3_mag_ff, 1'b0} : {1'b0, m3_mag_ff};
      rounded = (34'(mag2) + (34'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      angle   = m3_ctx_ff.neg ? (32'd0 - rounded[31:0]) : rounded[31:0];
      out_sat_in = 1'b0;
      unique case (m3_ctx_ff.op)
         OP_ATAN2, OP_ASIN: out_value_in = angle;
         OP_ACOS: begin
            unique case (m3_ctx_ff.acos)
               ACOS_AT_M1: out_value_in = 32'(acos_m1_ff);
               ACOS_ZERO:  out_value_in = 32'd0;
               default:    out_value_in = angle;
            endcase
         end
         OP_SQRT: out_value_in = m3_ctx_ff.rootv;
         OP_LEN2D, OP_LEN3D: begin
            out_sat_in   = m3_ctx_ff.rootv[31];
            out_value_in = m3_ctx_ff.rootv[31] ? 32'h7FFF_FFFF : m3_ctx_ff.rootv;
         end
         default: out_value_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m3_ctx_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_saturated    = out_sat_ff;

endmodule

// File: rtl/fitu_checker.sv
// fitu_checker: port-level assertions for the inverse trig unit, bound to the top level.
// Depends on fitu_pkg and fast_inverse_trig_unit_top.
module fitu_checker
   import fitu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_operation,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_result_value,
   input logic               rsp_saturated
);

   // every accepted request produces a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(PIPE_DEPTH) rsp_valid)
      else $error("request did not produce a result on time");

   // no result without a request that fixed latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a matching request");

   // a saturated result is the clamp value and comes from a length request
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> ((rsp_result_value == 32'sh7FFF_FFFF) &&
         (($past(req_operation, PIPE_DEPTH) == OP_LEN2D) ||
          ($past(req_operation, PIPE_DEPTH) == OP_LEN3D))))
      else $error("saturation flag on a non-length result");

   // unknown operation codes give zero
   a_unknown_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (($past(req_operation, PIPE_DEPTH) == 3'd6) ||
                     ($past(req_operation, PIPE_DEPTH) == 3'd7)))
      |-> ((rsp_result_value == 32'sd0) && !rsp_saturated))
      else $error("unknown operation gave a nonzero result");

endmodule

bind fast_inverse_trig_unit_top fitu_checker u_fitu_checker (.*);

// File: tb/fast_inverse_trig_unit_top_tb.sv
// Self-checking testbench for fast_inverse_trig_unit_top: table-driven directed requests,
// then random requests in several register settings, checked against an internal predictor.
// Depends on fitu_pkg and the fast_inverse_trig_unit_top RTL.
`timescale 1ns / 1ps

module fast_inverse_trig_unit_top_tb;
   import fitu_pkg::*;

   // Angle constants with 30 fraction bits
   localparam longint unsigned ANG_ONE  = 64'd1 << 30;
   localparam longint unsigned ANG_PI   = 64'd3373259426;
   localparam longint unsigned ANG_PI2  = ANG_PI >> 1;
   localparam longint unsigned ANG_PI4  = ANG_PI >> 2;
   localparam longint unsigned ANG_K309 = 64'd331786224;
   localparam int              RAND_ITEMS = 200;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic        typed;
      logic [31:0] val;
      logic        sat;
   } row_type;

   typedef struct {
      logic [31:0] val;
      logic        sat;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_operation;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic signed [31:0] req_operand_c;
   logic        rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic        rsp_saturated;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   // typed answer that travels with the request being driven
   logic        cur_typed;
   answer_type  cur_answer;

   logic [16:0] epsilon_reg;
   logic [18:0] acos_m1_reg;
   answer_type  answer_q[$];
   row_type     dir_tab[$];
   int          error_count;
   int          request_count;
   int          checked_count;

   fast_inverse_trig_unit_top uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .req_operand_c(req_operand_c),
      .rsp_valid(rsp_valid), .rsp_result_value(rsp_result_value),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // angle magnitude (30 fraction bits) from octant fold and polynomial
   function automatic longint unsigned angle_mag(longint unsigned ay, longint unsigned ax,
                                                 bit xneg);
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned r;
      longint unsigned ang;
      bit              swapped;
      hi = ax;
      lo = ay;
      swapped = 1'b0;
      if (ax == 0 && ay == 0) return 0;
      if (ax < ay) begin
         hi = ay;
         lo = ax;
         swapped = 1'b1;
      end
      r   = (lo << 30) / hi;
      ang = ((ANG_PI4 * r) >> 30) + ((ANG_K309 * ((r * (ANG_ONE - r)) >> 30)) >> 30);
      if (!xneg) begin
         if (swapped) ang = ANG_PI2 - ang;
      end else if (swapped) begin
         ang = ANG_PI2 + ang;
      end else begin
         ang = ANG_PI - ang;
      end
      return ang;
   endfunction

   // round half away from zero down to FRAC_BITS
   function automatic logic [31:0] round_angle(longint unsigned mag, bit neg);
      longint unsigned q;
      q = (mag + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
      return neg ? 32'(-q) : 32'(q);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic logic [31:0] asin_value(longint a);
      longint unsigned v;
      longint unsigned s;
      longint unsigned t;
      bit              neg;
      neg = a < 0;
      if (a > ONE_Q) a = ONE_Q;
      if (a < -ONE_Q) a = -ONE_Q;
      v = magnitude(a) << (30 - FRAC_BITS);
      if (v < (ANG_ONE >> 1)) begin
         s = floor_root((ANG_ONE << 30) - v * v);
      end else begin
         t = ANG_ONE - v;
         s = floor_root((t << 31) - t * t);
      end
      return round_angle(angle_mag(v, s, 1'b0), neg);
   endfunction

   function automatic logic [31:0] acos_value(longint a);
      longint t;
      longint n;
      longint d;
      t = a + ONE_Q;
      n = ONE_Q - a;
      d = a - ONE_Q;
      if (longint'(magnitude(t)) < longint'(epsilon_reg) || t == 0) return 32'(acos_m1_reg);
      if (longint'(magnitude(d)) < longint'(epsilon_reg)) return 32'd0;
      if (t < 0 || n <= 0) return 32'd0;
      return round_angle(2 * angle_mag(floor_root(longint'(n) << 32),
                                       floor_root(longint'(t) << 32), 1'b0), 1'b0);
   endfunction

   function automatic answer_type trig_predict(logic [2:0] op, logic [31:0] ra,
                                               logic [31:0] rb, logic [31:0] rc);
      answer_type      ans;
      longint          a;
      longint          b;
      longint          c;
      longint unsigned sum;
      longint unsigned r;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      c = longint'($signed(rc));
      ans.val = 32'd0;
      ans.sat = 1'b0;
      case (op)
         OP_ATAN2: ans.val = round_angle(angle_mag(magnitude(a), magnitude(b), b < 0), a < 0);
         OP_ASIN:  ans.val = asin_value(a);
         OP_ACOS:  ans.val = acos_value(a);
         OP_SQRT:  ans.val = a < 0 ? 32'd0 : 32'(floor_root(longint'(a) << FRAC_BITS));
         OP_LEN2D, OP_LEN3D: begin
            sum = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b);
            if (op == OP_LEN3D) sum = sum + magnitude(c) * magnitude(c);
            r = floor_root(sum);
            if (r > 64'h7FFF_FFFF) begin
               r = 64'h7FFF_FFFF;
               ans.sat = 1'b1;
            end
            ans.val = 32'(r);
         end
         default: ans.val = 32'd0;
      endcase
      return ans;
   endfunction

   // ---------------- capture and check ----------------

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, want);
   endtask

   // a request is taken when start is high and busy is low at the edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         request_count++;
         if (cur_typed) answer_q.push_back(cur_answer);
         else answer_q.push_back(trig_predict(req_operation, req_operand_a, req_operand_b,
                                              req_operand_c));
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_value, 32'd0);
         end else begin
            want = answer_q.pop_front();
            checked_count++;
            if (rsp_result_value !== want.val)
               report_mismatch("result_value", rsp_result_value, want.val);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", {31'd0, rsp_saturated}, {31'd0, want.sat});
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic add_row(logic [2:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic typed, logic [31:0] val, logic sat);
      row_type row;
      row.op = op; row.a = a; row.b = b; row.c = c;
      row.typed = typed; row.val = val; row.sat = sat;
      dir_tab.push_back(row);
   endtask

   // drive one request, hold until taken, then idle for the requested gap
   task automatic send_request(row_type row, int gap);
      start         <= 1'b1;
      req_operation <= row.op;
      req_operand_a <= row.a;
      req_operand_b <= row.b;
      req_operand_c <= row.c;
      cur_typed     <= row.typed;
      cur_answer    <= '{val: row.val, sat: row.sat};
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (answer_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // one register write; waits for the edge after the write before returning, so the next drive is clean
   task automatic write_csr(csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_EPSILON) epsilon_reg = value[16:0];
      else acos_m1_reg = value[18:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand(logic [2:0] op);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (pick <= 3) return $urandom();
      if (op == OP_ACOS || op == OP_ASIN) begin
         // land near plus or minus one and the epsilon bands
         if (pick <= 7)
            return 32'(($urandom_range(0, 1) ? 65536 : -65536)
                       + int'($urandom_range(0, 2 * int'(epsilon_reg) + 8))
                       - int'(epsilon_reg) - 4);
         return 32'(int'($urandom_range(0, 131072)) - 65536);
      end
      return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
   endfunction

   task automatic random_phase(int count);
      row_type row;
      bit      burst;
      int      gap;
      burst = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 24) == 0) burst = ~burst;
         row.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
         row.a = rand_operand(row.op);
         row.b = rand_operand(row.op);
         row.c = rand_operand(row.op);
         row.typed = 1'b0; row.val = 32'd0; row.sat = 1'b0;
         gap = burst ? 0 : $urandom_range(0, 12);
         send_request(row, gap);
         // pause the request stream until the pipeline empties
         if (i == count / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_ATAN2;
      req_operand_a = '0;
      req_operand_b = '0;
      req_operand_c = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_EPSILON;
      csr_data      = '0;
      cur_typed     = 1'b0;
      cur_answer    = '{val: 32'd0, sat: 1'b0};
      epsilon_reg   = EPS_RESET;
      acos_m1_reg   = ACOS_M1_RESET;
      error_count   = 0;
      request_count = 0;
      checked_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset register values
      add_row(OP_ATAN2, 32'd0, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_ATAN2, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 0, 0, 0);
      add_row(OP_ATAN2, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 0, 0, 0);
      add_row(OP_ATAN2, 32'h8000_0000, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ATAN2, 32'd0, 32'h8000_0000, 32'd0, 0, 0, 0);
      add_row(OP_ATAN2, 32'd65536, 32'hFFFF_0000, 32'd0, 0, 0, 0);
      add_row(OP_ASIN, 32'd0, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_ASIN, 32'h7FFF_FFFF, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ASIN, 32'h8000_0000, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ASIN, 32'd32768, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ASIN, 32'd32767, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ACOS, 32'hFFFF_0000, 32'd0, 32'd0, 1, 32'(ACOS_M1_RESET), 0);
      add_row(OP_ACOS, 32'd65536, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_ACOS, 32'h7FFF_FFFF, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_ACOS, 32'h8000_0000, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_ACOS, 32'(-65536 + 66), 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_ACOS, 32'd0, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_SQRT, 32'hFFFF_FFFF, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(OP_SQRT, 32'd65536, 32'd0, 32'd0, 1, 32'd65536, 0);
      add_row(OP_SQRT, 32'h7FFF_FFFF, 32'd0, 32'd0, 0, 0, 0);
      add_row(OP_LEN2D, 32'h8000_0000, 32'h8000_0000, 32'd0, 1, 32'h7FFF_FFFF, 1);
      add_row(OP_LEN2D, 32'd196608, 32'hFFFC_0000, 32'd0, 1, 32'd327680, 0);
      add_row(OP_LEN3D, 32'd0, 32'd0, 32'h8000_0000, 1, 32'd0 + 32'h8000_0000 - 1, 1);
      add_row(OP_LEN3D, 32'd0, 32'd0, 32'd0, 1, 32'd0, 0);
      add_row(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0);
      add_row(3'd7, 32'h1234_5678, 32'd1, 32'd2, 1, 32'd0, 0);
      foreach (dir_tab[i]) send_request(dir_tab[i], $urandom_range(0, 3));
      drain_results();

      // random requests under several register settings
      random_phase(RAND_ITEMS);
      write_csr(CSR_EPSILON, 32'd0);
      write_csr(CSR_ACOS_M1, 32'd0);
      send_request('{op: OP_ACOS, a: 32'hFFFF_0000, b: 0, c: 0, typed: 1, val: 0, sat: 0}, 0);
      random_phase(RAND_ITEMS);
      write_csr(CSR_EPSILON, 32'd65536);
      write_csr(CSR_ACOS_M1, 32'd262144);
      random_phase(RAND_ITEMS);
      write_csr(CSR_EPSILON, $urandom_range(0, 4096));
      write_csr(CSR_ACOS_M1, $urandom_range(0, 262144));
      random_phase(RAND_ITEMS);

      $display("%0d requests sent and %0d results checked over four register settings",
               request_count, checked_count);
      if (error_count == 0 && answer_q.size() == 0) begin
         $display("fast_inverse_trig_unit_top_tb: clean");
      end else begin
         $display("fast_inverse_trig_unit_top_tb: errors");
      end
      $finish;
   end

   // run time limit
   initial begin
      #20ms;
      $display("fast_inverse_trig_unit_top_tb: errors");
      $finish;
   end

endmodule

// File: fast_inverse_trig_unit_top.f
rtl/fitu_pkg.sv
rtl/fitu_sqrt_cell.sv
rtl/fitu_div_cell.sv
rtl/fast_inverse_trig_unit_top.sv
rtl/fitu_checker.sv
tb/fast_inverse_trig_unit_top_tb.sv
